@@ src/ssaa_pkg.sv @@
// ----------------------------------------------------------------------------
// ssaa_pkg
// Shared types and constants of the block downscaler: pixel width, register
// indexes and reset values, Gaussian weights, queue status and config beat.
// ----------------------------------------------------------------------------
package ssaa_pkg;

    localparam int PIX_W     = 8;
    localparam int OUT_COL_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int SCALE_W   = 4;
    localparam int WIDTH_W   = 13;
    localparam int Q_DEPTH   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH  = 2'd2;

    localparam logic [SCALE_W-1:0] RST_SCALE_FACTOR = 4'd2;
    localparam logic               RST_COLOR_MODE   = 1'b1;
    localparam logic [WIDTH_W-1:0] RST_INPUT_WIDTH  = 13'd4096;

    localparam int GAUSS_F   = 3;
    localparam int GAUSS_DIV = 16;

    localparam logic [2:0] GAUSS_W [3][3] = '{
        '{3'd1, 3'd2, 3'd1},
        '{3'd2, 3'd4, 3'd2},
        '{3'd1, 3'd2, 3'd1}
    };

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic empty;
        logic full;
        logic last_slot;
    } t_q_status;

endpackage

@@ src/ssaa_queue.sv @@
// ----------------------------------------------------------------------------
// ssaa_queue
// Short register queue between the accumulating front and the dividing back.
// ----------------------------------------------------------------------------
module ssaa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_data,
    output ssaa_pkg::t_q_status   o_stat
);
    import ssaa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_count != CNT_W'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data           = r_mem[r_rd_ptr];
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.last_slot = (r_count == CNT_W'(DEPTH - 1));

endmodule

@@ src/ssaa_front.sv @@
// ----------------------------------------------------------------------------
// ssaa_front
// Config registers, raster position counters and the line accumulator:
// weights each pixel, sums it into its block entry and hands finished
// block sums to the queue.
// ----------------------------------------------------------------------------
module ssaa_front #(
    parameter int MAX_IN_WIDTH = 4096,
    parameter int MAX_FACTOR   = 8,
    parameter int SUM_W        = 15,
    parameter int QW           = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ssaa_pkg::t_cfg_wr          i_cfg,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_frame_start,
    input  logic [ssaa_pkg::PIX_W-1:0] i_ch0,
    input  logic [ssaa_pkg::PIX_W-1:0] i_ch1,
    input  logic [ssaa_pkg::PIX_W-1:0] i_ch2,
    output logic                       o_q_push,
    output logic [QW-1:0]              o_q_data,
    input  ssaa_pkg::t_q_status        i_q_stat
);
    import ssaa_pkg::*;

    localparam int SUM_DEPTH = MAX_IN_WIDTH / 2;
    localparam int ADDR_W    = $clog2(SUM_DEPTH);
    localparam int BC_W      = $clog2(SUM_DEPTH + 1);
    localparam int COL_W     = $clog2(MAX_IN_WIDTH);
    localparam int WW        = $clog2(MAX_IN_WIDTH + 1);
    localparam int FW        = $clog2(MAX_FACTOR + 1);
    localparam int CNT_W     = $clog2(MAX_FACTOR);
    localparam int MW        = BC_W + 1 + FW;
    localparam int VW        = PIX_W + 3;

    logic [SCALE_W-1:0] r_scale;
    logic               r_color;
    logic [WIDTH_W-1:0] r_width;

    logic [COL_W-1:0]   r_in_col;
    logic [CNT_W-1:0]   r_row;
    logic [CNT_W-1:0]   r_cib;
    logic [BC_W-1:0]    r_bc;

    logic [3*SUM_W-1:0] r_mem [SUM_DEPTH];
    logic [3*SUM_W-1:0] r_rd_data;
    logic               r_wr_valid;
    logic [ADDR_W-1:0]  r_wr_addr;
    logic [3*SUM_W-1:0] r_wr_data;

    logic               r_p1_valid;
    logic [ADDR_W-1:0]  r_p1_addr;
    logic [VW-1:0]      r_p1_v [3];
    logic               r_p1_first;
    logic               r_p1_last;
    logic               r_p1_row_last;
    logic [FW-1:0]      r_p1_f;

    logic [FW-1:0]      f_eff;
    logic [WW-1:0]      w_eff;
    logic               accept;

    logic [COL_W-1:0]   c0;
    logic [COL_W-1:0]   c1;
    logic [CNT_W-1:0]   row0;
    logic [CNT_W-1:0]   cib0;
    logic [BC_W-1:0]    bc0;
    logic [BC_W-1:0]    bc1;
    logic [FW-1:0]      row1;
    logic [CNT_W-1:0]   cib1;
    logic [CNT_W-1:0]   row2;
    logic [CNT_W-1:0]   cib2;
    logic [MW-1:0]      end_a;
    logic [MW-1:0]      end_b;
    logic               use_px;
    logic               first_px;
    logic               last_px;
    logic               row_last;
    logic [2:0]         weight;
    logic [VW-1:0]      v [3];
    logic [WW-1:0]      n_in_col;
    logic [FW-1:0]      n_cib;
    logic [FW-1:0]      n_row;
    logic [BC_W-1:0]    n_bc;

    logic [3*SUM_W-1:0] base;
    logic [3*SUM_W-1:0] n_sum;

    // Effective factor and width
    always_comb begin
        if (r_scale < SCALE_W'(2)) begin
            f_eff = FW'(2);
        end else if (32'(r_scale) > MAX_FACTOR) begin
            f_eff = FW'(MAX_FACTOR);
        end else begin
            f_eff = FW'(r_scale);
        end
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > MAX_IN_WIDTH) begin
            w_eff = WW'(MAX_IN_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
    end

    // Position of this pixel and the counters after it
    always_comb begin
        c0   = i_frame_start ? '0 : r_in_col;
        row0 = i_frame_start ? '0 : r_row;
        cib0 = i_frame_start ? '0 : r_cib;
        bc0  = i_frame_start ? '0 : r_bc;

        if (WW'(c0) >= w_eff) begin
            c1   = '0;
            cib1 = '0;
            bc1  = '0;
            row1 = FW'(row0) + FW'(1);
        end else begin
            c1   = c0;
            cib1 = cib0;
            bc1  = bc0;
            row1 = FW'(row0);
        end
        row2 = (row1 >= f_eff) ? '0 : CNT_W'(row1);
        cib2 = (FW'(cib1) >= f_eff) ? '0 : cib1;

        end_a    = (MW'(bc1) + MW'(1)) * MW'(f_eff);
        end_b    = (MW'(bc1) + MW'(2)) * MW'(f_eff);
        use_px   = (end_a <= MW'(w_eff)) && (bc1 < BC_W'(SUM_DEPTH));
        row_last = (end_b > MW'(w_eff));
        first_px = (row2 == '0) && (cib2 == '0);
        last_px  = (FW'(row2) == f_eff - FW'(1)) && (FW'(cib2) == f_eff - FW'(1));

        weight = (f_eff == FW'(GAUSS_F)) ? GAUSS_W[row2[1:0]][cib2[1:0]] : 3'd1;
        v[0]   = VW'(i_ch0) * VW'(weight);
        v[1]   = r_color ? VW'(i_ch1) * VW'(weight) : '0;
        v[2]   = r_color ? VW'(i_ch2) * VW'(weight) : '0;

        n_cib = FW'(cib2) + FW'(1);
        n_bc  = bc1;
        n_row = FW'(row2);
        if (n_cib >= f_eff) begin
            n_cib = '0;
            n_bc  = bc1 + BC_W'(1);
        end
        n_in_col = WW'(c1) + WW'(1);
        if (n_in_col >= w_eff) begin
            n_in_col = '0;
            n_cib    = '0;
            n_bc     = '0;
            n_row    = FW'(row2) + FW'(1);
            if (n_row >= f_eff) begin
                n_row = '0;
            end
        end
    end

    assign o_full = i_q_stat.full || (i_q_stat.last_slot && r_p1_valid && r_p1_last);
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= RST_SCALE_FACTOR;
            r_color    <= RST_COLOR_MODE;
            r_width    <= RST_INPUT_WIDTH;
            r_in_col   <= '0;
            r_row      <= '0;
            r_cib      <= '0;
            r_bc       <= '0;
            r_p1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.index)
                    CFG_SCALE_FACTOR: r_scale <= i_cfg.data[SCALE_W-1:0];
                    CFG_COLOR_MODE:   r_color <= i_cfg.data[0];
                    CFG_INPUT_WIDTH:  r_width <= i_cfg.data[WIDTH_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_in_col <= COL_W'(n_in_col);
                r_row    <= CNT_W'(n_row);
                r_cib    <= CNT_W'(n_cib);
                r_bc     <= n_bc;
            end
            r_p1_valid <= accept && use_px;
            if (r_p1_valid) begin
                r_wr_valid <= 1'b1;
            end
        end
    end

    // Stage one: capture the beat and read its block entry
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data     <= r_mem[bc1[ADDR_W-1:0]];
            r_p1_addr     <= bc1[ADDR_W-1:0];
            r_p1_v        <= v;
            r_p1_first    <= first_px;
            r_p1_last     <= last_px;
            r_p1_row_last <= row_last;
            r_p1_f        <= f_eff;
        end
    end

    // Stage two: add into the entry, forward the latest write
    always_comb begin
        if (r_p1_first) begin
            base = '0;
        end else if (r_wr_valid && (r_wr_addr == r_p1_addr)) begin
            base = r_wr_data;
        end else begin
            base = r_rd_data;
        end
        for (int k = 0; k < 3; k++) begin
            n_sum[k*SUM_W +: SUM_W] = base[k*SUM_W +: SUM_W] + SUM_W'(r_p1_v[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            r_mem[r_p1_addr] <= n_sum;
            r_wr_addr        <= r_p1_addr;
            r_wr_data        <= n_sum;
        end
    end

    assign o_q_push = r_p1_valid && r_p1_last;
    assign o_q_data = {r_p1_row_last, r_p1_f, r_p1_addr, n_sum};

endmodule

@@ src/ssaa_back.sv @@
// ----------------------------------------------------------------------------
// ssaa_back
// Block sum divider: reciprocal multiply, one correction step, result
// register with pop handshake.
// ----------------------------------------------------------------------------
module ssaa_back #(
    parameter int MAX_IN_WIDTH = 4096,
    parameter int MAX_FACTOR   = 8,
    parameter int SUM_W        = 15,
    parameter int QW           = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [QW-1:0]                  i_q_data,
    input  ssaa_pkg::t_q_status            i_q_stat,
    output logic                           o_q_pop,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [ssaa_pkg::PIX_W-1:0]     o_ch0,
    output logic [ssaa_pkg::PIX_W-1:0]     o_ch1,
    output logic [ssaa_pkg::PIX_W-1:0]     o_ch2,
    output logic [ssaa_pkg::OUT_COL_W-1:0] o_column,
    output logic                           o_row_last
);
    import ssaa_pkg::*;

    localparam int SUM_DEPTH = MAX_IN_WIDTH / 2;
    localparam int ADDR_W    = $clog2(SUM_DEPTH);
    localparam int FW        = $clog2(MAX_FACTOR + 1);
    localparam int MAX_DIV   = (MAX_FACTOR * MAX_FACTOR > GAUSS_DIV) ?
                               MAX_FACTOR * MAX_FACTOR : GAUSS_DIV;
    localparam int DW        = $clog2(MAX_DIV + 1);
    localparam int SH        = SUM_W;
    localparam int RW        = SUM_W - 1;
    localparam int PW        = SUM_W + RW;

    logic [DW-1:0] w_div [MAX_FACTOR + 1];
    logic [RW-1:0] w_rcp [MAX_FACTOR + 1];

    for (genvar g = 0; g <= MAX_FACTOR; g++) begin : g_div
        localparam int DIV = (g == GAUSS_F) ? GAUSS_DIV : ((g < 2) ? 4 : g * g);
        localparam longint RCP = (longint'(1) << SH) / DIV;
        assign w_div[g] = DW'(DIV);
        assign w_rcp[g] = RW'(RCP);
    end

    logic [SUM_W-1:0]     q_sum [3];
    logic [ADDR_W-1:0]    q_col;
    logic [FW-1:0]        q_f;
    logic                 q_last;
    logic                 en;

    logic                 r_s1_valid;
    logic [SUM_W-1:0]     r_s1_sum  [3];
    logic [PW-1:0]        r_s1_prod [3];
    logic [FW-1:0]        r_s1_f;
    logic [ADDR_W-1:0]    r_s1_col;
    logic                 r_s1_last;

    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_ch [3];
    logic [ADDR_W-1:0]    r_out_col;
    logic                 r_out_last;

    logic [SUM_W-1:0]     quo0 [3];
    logic [SUM_W+DW-1:0]  back_prod [3];
    logic [SUM_W-1:0]     rem [3];
    logic [SUM_W-1:0]     quo [3];
    logic [DW-1:0]        div_s1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_sum[k] = i_q_data[k*SUM_W +: SUM_W];
        end
        q_col  = i_q_data[3*SUM_W +: ADDR_W];
        q_f    = i_q_data[3*SUM_W+ADDR_W +: FW];
        q_last = i_q_data[3*SUM_W+ADDR_W+FW];
    end

    assign en      = !r_out_valid || i_pop;
    assign o_q_pop = en && !i_q_stat.empty;

    always_comb begin
        div_s1 = w_div[r_s1_f];
        for (int k = 0; k < 3; k++) begin
            quo0[k]      = SUM_W'(r_s1_prod[k] >> SH);
            back_prod[k] = (SUM_W+DW)'(quo0[k]) * (SUM_W+DW)'(div_s1);
            rem[k]       = r_s1_sum[k] - SUM_W'(back_prod[k]);
            quo[k]       = (rem[k] >= SUM_W'(div_s1)) ? quo0[k] + SUM_W'(1) : quo0[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= !i_q_stat.empty;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_sum[k]  <= q_sum[k];
                r_s1_prod[k] <= PW'(q_sum[k]) * PW'(w_rcp[q_f]);
                r_out_ch[k]  <= quo[k][PIX_W-1:0];
            end
            r_s1_f     <= q_f;
            r_s1_col   <= q_col;
            r_s1_last  <= q_last;
            r_out_col  <= r_s1_col;
            r_out_last <= r_s1_last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_ch0      = r_out_ch[0];
    assign o_ch1      = r_out_ch[1];
    assign o_ch2      = r_out_ch[2];
    assign o_column   = OUT_COL_W'(r_out_col);
    assign o_row_last = r_out_last;

endmodule

@@ src/ssaa_block_downscaler.sv @@
// ----------------------------------------------------------------------------
// ssaa_block_downscaler
// Integer-factor image downscaler: box average, or 3x3 Gaussian for factor 3.
//
//   channel  handshake           payload
//   config   i_cfg_we            i_cfg_index, i_cfg_data
//   pixel    push / full         i_frame_start, i_in_ch0..i_in_ch2
//   result   pop / empty         o_out_ch0..o_out_ch2, o_out_column, o_row_last
//
// One pixel beat per cycle while full is low. After the edge that accepts the
// last pixel of its block, the block sum is added and written to the queue,
// then passes the divider's product register and its result register. full
// rises when the four-entry queue of block sums is full, or holds three with
// a block sum about to enter; pop stalls hold the divider and then the queue.
// Reset clears counters and the queue; the line accumulator needs no clear.
// ----------------------------------------------------------------------------
module ssaa_block_downscaler #(
    parameter int MAX_IN_WIDTH = 4096,
    parameter int MAX_FACTOR   = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ssaa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssaa_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic                             i_frame_start,
    input  logic [ssaa_pkg::PIX_W-1:0]       i_in_ch0,
    input  logic [ssaa_pkg::PIX_W-1:0]       i_in_ch1,
    input  logic [ssaa_pkg::PIX_W-1:0]       i_in_ch2,
    output logic                             empty,
    input  logic                             pop,
    output logic [ssaa_pkg::PIX_W-1:0]       o_out_ch0,
    output logic [ssaa_pkg::PIX_W-1:0]       o_out_ch1,
    output logic [ssaa_pkg::PIX_W-1:0]       o_out_ch2,
    output logic [ssaa_pkg::OUT_COL_W-1:0]   o_out_column,
    output logic                             o_row_last
);
    import ssaa_pkg::*;

    localparam int SUM_DEPTH = MAX_IN_WIDTH / 2;
    localparam int ADDR_W    = $clog2(SUM_DEPTH);
    localparam int FW        = $clog2(MAX_FACTOR + 1);
    localparam int MAX_DIV   = (MAX_FACTOR * MAX_FACTOR > GAUSS_DIV) ?
                               MAX_FACTOR * MAX_FACTOR : GAUSS_DIV;
    localparam int SUM_W     = $clog2(MAX_DIV * 255 + 1) + 1;
    localparam int QW        = 3 * SUM_W + ADDR_W + FW + 1;

    t_cfg_wr       cfg;
    t_q_status     q_stat;
    logic          q_push;
    logic          q_pop;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    ssaa_front #(
        .MAX_IN_WIDTH (MAX_IN_WIDTH),
        .MAX_FACTOR   (MAX_FACTOR),
        .SUM_W        (SUM_W),
        .QW           (QW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_push        (push),
        .o_full        (full),
        .i_frame_start (i_frame_start),
        .i_ch0         (i_in_ch0),
        .i_ch1         (i_in_ch1),
        .i_ch2         (i_in_ch2),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata),
        .i_q_stat      (q_stat)
    );

    ssaa_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_stat  (q_stat)
    );

    ssaa_back #(
        .MAX_IN_WIDTH (MAX_IN_WIDTH),
        .MAX_FACTOR   (MAX_FACTOR),
        .SUM_W        (SUM_W),
        .QW           (QW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (q_rdata),
        .i_q_stat   (q_stat),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_ch0      (o_out_ch0),
        .o_ch1      (o_out_ch1),
        .o_ch2      (o_out_ch2),
        .o_column   (o_out_column),
        .o_row_last (o_row_last)
    );

endmodule
